// ===== rtl/pbpzf_pkg.sv =====
`default_nettype none

package pbpzf_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Input tdata layout, lowest bit first
    localparam int ZONE_LSB   = 0;
    localparam int VERTEX_LSB = 2;
    localparam int X_LSB      = 6;
    localparam int Y_LSB      = 38;
    localparam int Z_LSB      = 70;
    localparam int INT_LSB    = 102;
    localparam int HLOW_LSB   = 110;
    localparam int HHIGH_LSB  = 142;
    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 104;

    // Item kinds carried in s_axis_tuser
    localparam logic [OP_W-1:0] OP_POINT  = 2'd0;
    localparam logic [OP_W-1:0] OP_VERTEX = 2'd1;
    localparam logic [OP_W-1:0] OP_ZONE   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MAX = 3'd5;

    // Crop box defaults, Q16.16
    localparam logic signed [CFG_W-1:0] RST_X_MIN = -32'sd32768;
    localparam logic signed [CFG_W-1:0] RST_X_MAX = 32'sd32768;
    localparam logic signed [CFG_W-1:0] RST_Y_MIN = -32'sd32768;
    localparam logic signed [CFG_W-1:0] RST_Y_MAX = 32'sd32768;
    localparam logic signed [CFG_W-1:0] RST_Z_MIN = -32'sd32768;
    localparam logic signed [CFG_W-1:0] RST_Z_MAX = 32'sd45875;

    // Tag that follows a vertex read into the edge pipeline
    typedef struct packed {
        logic vld;    // a vertex read is in flight
        logic prime;  // closing vertex of the ring, only loads the previous vertex
        logic last;   // last edge of the zone
    } edge_tag_t;

    // Verdict of one zone
    typedef struct packed {
        logic vld;
        logic hit;    // point lies within the polygon
    } zone_res_t;

endpackage

`default_nettype wire

// ===== rtl/point_box_polygon_zone_filter.sv =====
`default_nettype none

// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: op; tdata: zone, vertex, coord_x, coord_y, coord_z, intensity,
//                height_low, height_high
// m_axis    out  tdata: out_x, out_y, out_z, out_intensity
// cfg       in   cfg_wr_en, cfg_index, cfg_data; crop box bounds, write only
//
// Zone writes never close the input. A point inside the crop box skips the zone walk. Otherwise a point
// visits each zone in turn and walks the edges of every non-empty zone whose height range holds z:
// the vertex RAM gives one vertex per cycle, one polygon edge per cycle. Zone walking stops
// early once a zone holds the point. Reset clears zones to empty and the crop box to defaults.
// A kept point waits in the output register; the next item is taken meanwhile.

module point_box_polygon_zone_filter
    import pbpzf_pkg::*;
#(
    parameter int ZONES    = 4,
    parameter int VERTICES = 8
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire [S_TDATA_W-1:0]   s_axis_tdata,   // zone, vertex, coord_x, coord_y, coord_z,
                                                  // intensity, height_low, height_high
    input  wire [OP_W-1:0]        s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // out_x, out_y, out_z, out_intensity
    input  wire                   cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_W-1:0]       cfg_data
);

    localparam int DEPTH = ZONES * VERTICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ZW    = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int VW    = $clog2(VERTICES);
    localparam int CW    = $clog2(VERTICES + 1);

    typedef enum logic [2:0] {S_IDLE, S_ZONE, S_EDGE, S_DRAIN, S_DONE} state_t;

    state_t state_reg;

    // Input fields
    logic [1:0]                s_zone;
    logic [3:0]                s_vertex;
    logic signed [COORD_W-1:0] s_x, s_y, s_z, s_hlow, s_hhigh;
    logic [7:0]                s_int;
    logic                      s_xfer;

    assign s_zone   = s_axis_tdata[ZONE_LSB +: 2];
    assign s_vertex = s_axis_tdata[VERTEX_LSB +: 4];
    assign s_x      = s_axis_tdata[X_LSB +: COORD_W];
    assign s_y      = s_axis_tdata[Y_LSB +: COORD_W];
    assign s_z      = s_axis_tdata[Z_LSB +: COORD_W];
    assign s_int    = s_axis_tdata[INT_LSB +: 8];
    assign s_hlow   = s_axis_tdata[HLOW_LSB +: COORD_W];
    assign s_hhigh  = s_axis_tdata[HHIGH_LSB +: COORD_W];
    assign s_xfer   = s_axis_tvalid && s_axis_tready;

    // Crop box registers
    logic signed [CFG_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg, z_min_reg, z_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= RST_X_MIN;
            x_max_reg <= RST_X_MAX;
            y_min_reg <= RST_Y_MIN;
            y_max_reg <= RST_Y_MAX;
            z_min_reg <= RST_Z_MIN;
            z_max_reg <= RST_Z_MAX;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_X_MIN: x_min_reg <= cfg_data;
                CFG_X_MAX: x_max_reg <= cfg_data;
                CFG_Y_MIN: y_min_reg <= cfg_data;
                CFG_Y_MAX: y_max_reg <= cfg_data;
                CFG_Z_MIN: z_min_reg <= cfg_data;
                CFG_Z_MAX: z_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zone headers: vertex count and height range
    logic [CW-1:0]             zone_cnt_reg  [ZONES];
    logic signed [COORD_W-1:0] zone_low_reg  [ZONES];
    logic signed [COORD_W-1:0] zone_high_reg [ZONES];
    logic [DEPTH-1:0]          vtx_valid_reg;

    logic          zone_ok, vtx_ok, vtx_wr, zone_wr;
    logic [ZW-1:0] wr_zone;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] cnt_sat;

    assign zone_ok = int'(s_zone) < ZONES;
    assign vtx_ok  = int'(s_vertex) < VERTICES;
    assign vtx_wr  = s_xfer && (s_axis_tuser == OP_VERTEX) && zone_ok && vtx_ok;
    assign zone_wr = s_xfer && (s_axis_tuser == OP_ZONE) && zone_ok;
    assign wr_zone = ZW'(s_zone);
    assign wr_addr = AW'(int'(s_zone) * VERTICES + int'(s_vertex));
    assign cnt_sat = (int'(s_vertex) > VERTICES) ? CW'(VERTICES) : CW'(s_vertex);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_valid_reg <= '0;
            for (int z = 0; z < ZONES; z++)
            begin
                zone_cnt_reg[z]  <= '0;
                zone_low_reg[z]  <= '0;
                zone_high_reg[z] <= '0;
            end
        end
        else
        begin
            if (vtx_wr)
            begin
                vtx_valid_reg[wr_addr] <= 1'b1;
            end
            if (zone_wr)
            begin
                zone_cnt_reg[wr_zone]  <= cnt_sat;
                zone_low_reg[wr_zone]  <= s_hlow;
                zone_high_reg[wr_zone] <= s_hhigh;
            end
        end
    end

    // Point under test
    logic signed [COORD_W-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [7:0]                pt_int_reg;

    always_ff @(posedge clk)
    begin
        if (s_xfer && (s_axis_tuser == OP_POINT))
        begin
            pt_x_reg   <= s_x;
            pt_y_reg   <= s_y;
            pt_z_reg   <= s_z;
            pt_int_reg <= s_int;
        end
    end

    logic crop_hit;
    assign crop_hit = (s_x >= x_min_reg) && (s_x <= x_max_reg) &&
                      (s_y >= y_min_reg) && (s_y <= y_max_reg) &&
                      (s_z >= z_min_reg) && (s_z <= z_max_reg);

    // Zone walk control
    logic [ZW-1:0] k_reg;
    logic [VW-1:0] i_reg;
    logic          crop_hit_reg, hit_reg;
    logic [CW-1:0] cnt_k;
    logic          zone_elig, k_last, edge_last;

    assign cnt_k     = zone_cnt_reg[k_reg];
    assign zone_elig = (cnt_k != '0) && (pt_z_reg >= zone_low_reg[k_reg]) &&
                       (pt_z_reg <= zone_high_reg[k_reg]);
    assign k_last    = k_reg == ZW'(ZONES - 1);
    assign edge_last = (CW'(i_reg) + CW'(1)) == cnt_k;

    // Vertex read issue
    edge_tag_t     issue_tag, rd_tag_reg;
    logic [VW-1:0] rd_vidx;
    logic [AW-1:0] rd_addr;
    logic          vld_rd_reg;

    always_comb
    begin
        issue_tag = '0;
        rd_vidx   = i_reg;
        if ((state_reg == S_ZONE) && !crop_hit_reg && !hit_reg && zone_elig)
        begin
            issue_tag.vld   = 1'b1;
            issue_tag.prime = 1'b1;
            rd_vidx         = VW'(cnt_k - CW'(1));
        end
        else if (state_reg == S_EDGE)
        begin
            issue_tag.vld  = 1'b1;
            issue_tag.last = edge_last;
        end
    end

    assign rd_addr = AW'(int'(k_reg) * VERTICES + int'(rd_vidx));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            rd_tag_reg <= issue_tag;
            vld_rd_reg <= vtx_valid_reg[rd_addr];
        end
    end

    // Vertex store: {y, x} per entry
    logic [2*COORD_W-1:0]      ram_rd_data;
    logic signed [COORD_W-1:0] vert_x, vert_y;

    pbpzf_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (DEPTH)
    ) u_vtx_ram (
        .clk     (clk),
        .wr_en   (vtx_wr),
        .wr_addr (wr_addr),
        .wr_data ({s_y, s_x}),
        .rd_en   (issue_tag.vld),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Never-written vertices read as zero
    assign vert_x = vld_rd_reg ? ram_rd_data[COORD_W-1:0] : '0;
    assign vert_y = vld_rd_reg ? ram_rd_data[2*COORD_W-1:COORD_W] : '0;

    logic      edge_busy;
    zone_res_t zres;

    pbpzf_edge u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_tag (rd_tag_reg),
        .vert_x (vert_x),
        .vert_y (vert_y),
        .pt_x   (pt_x_reg),
        .pt_y   (pt_y_reg),
        .busy   (edge_busy),
        .zres   (zres)
    );

    // Sequencer and output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_load;

    // Kept point moves into the output register once it is free
    assign out_load = (state_reg == S_DONE) && !crop_hit_reg && !hit_reg &&
                      (!m_tvalid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            i_reg        <= '0;
            crop_hit_reg <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {pt_int_reg, pt_z_reg, pt_y_reg, pt_x_reg};
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (zres.vld && zres.hit)
            begin
                hit_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && (s_axis_tuser == OP_POINT))
                    begin
                        crop_hit_reg <= crop_hit;
                        hit_reg      <= 1'b0;
                        k_reg        <= '0;
                        state_reg    <= S_ZONE;
                    end
                end
                S_ZONE:
                begin
                    priority if (crop_hit_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (hit_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else if (zone_elig)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_EDGE;
                    end
                    else if (k_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + ZW'(1);
                    end
                end
                S_EDGE:
                begin
                    i_reg <= i_reg + VW'(1);
                    if (edge_last)
                    begin
                        if (k_last)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            k_reg     <= k_reg + ZW'(1);
                            state_reg <= S_ZONE;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_tag_reg.vld && !edge_busy)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (crop_hit_reg || hit_reg || out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/pbpzf_ram.sv =====
`default_nettype none

module pbpzf_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire             clk,
    input  wire             wr_en,
    input  wire [AW-1:0]    wr_addr,
    input  wire [WIDTH-1:0] wr_data,
    input  wire             rd_en,
    input  wire [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pbpzf_edge.sv =====
`default_nettype none

module pbpzf_edge
    import pbpzf_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  edge_tag_t                 in_tag,
    input  wire signed [COORD_W-1:0]  vert_x,
    input  wire signed [COORD_W-1:0]  vert_y,
    input  wire signed [COORD_W-1:0]  pt_x,
    input  wire signed [COORD_W-1:0]  pt_y,
    output logic                      busy,
    output zone_res_t                 zres
);

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;

    logic signed [DW-1:0] a_d, c_d, dy_d, ry_d, dya_d, rya_d;
    logic                 cross_d;

    logic                 s1_vld_reg, s1_last_reg, s1_cross_reg;
    logic signed [DW-1:0] s1_a_reg, s1_c_reg, s1_dya_reg, s1_rya_reg;

    logic                 s2_vld_reg, s2_last_reg, s2_cross_reg;
    logic signed [PW-1:0] s2_p1_reg, s2_p2_reg;

    logic      par_reg, par_next, flip;
    zone_res_t zres_reg;

    // Edge from vertex i (arriving) to vertex j (previous), all differences at 33 bits
    always_comb
    begin
        a_d     = {pt_x[COORD_W-1], pt_x} - {vert_x[COORD_W-1], vert_x};
        c_d     = {prev_x_reg[COORD_W-1], prev_x_reg} - {vert_x[COORD_W-1], vert_x};
        dy_d    = {prev_y_reg[COORD_W-1], prev_y_reg} - {vert_y[COORD_W-1], vert_y};
        ry_d    = {pt_y[COORD_W-1], pt_y} - {vert_y[COORD_W-1], vert_y};
        dya_d   = dy_d[DW-1] ? -dy_d : dy_d;
        rya_d   = dy_d[DW-1] ? -ry_d : ry_d;
        cross_d = (vert_y > pt_y) != (prev_y_reg > pt_y);
    end

    // Crossing test on registered products: x - xi < (xj - xi) * ry / dy
    assign flip     = s2_cross_reg && (s2_p1_reg < s2_p2_reg);
    assign par_next = par_reg ^ flip;

    // Pipeline control and parity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            par_reg     <= 1'b0;
            zres_reg    <= '0;
        end
        else
        begin
            s1_vld_reg  <= in_tag.vld && !in_tag.prime;
            s1_last_reg <= in_tag.last;
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
            zres_reg    <= '{vld: s2_vld_reg && s2_last_reg,
                             hit: s2_vld_reg && s2_last_reg && par_next};
            // parity restarts after the last edge of a zone
            if (s2_vld_reg)
            begin
                par_reg <= s2_last_reg ? 1'b0 : par_next;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_tag.vld)
        begin
            prev_x_reg <= vert_x;
            prev_y_reg <= vert_y;
        end
        s1_cross_reg <= cross_d;
        s1_a_reg     <= a_d;
        s1_c_reg     <= c_d;
        s1_dya_reg   <= dya_d;
        s1_rya_reg   <= rya_d;
        s2_cross_reg <= s1_cross_reg;
        s2_p1_reg    <= s1_a_reg * s1_dya_reg;
        s2_p2_reg    <= s1_c_reg * s1_rya_reg;
    end

    assign busy = s1_vld_reg || s2_vld_reg || zres_reg.vld;
    assign zres = zres_reg;

endmodule

`default_nettype wire

// ===== rtl/pbpzf_chk.sv =====
`default_nettype none

module pbpzf_chk
    import pbpzf_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  s_axis_tvalid,
    input wire                  s_axis_tready,
    input wire [OP_W-1:0]       s_axis_tuser,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [M_TDATA_W-1:0]  m_axis_tdata
);

    logic s_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A new result is loaded only at the end of a point, while input is closed
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without point processing");

    // Zone writes and unused ops leave the input ready and give no result
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && (s_axis_tuser != OP_POINT) |=> s_axis_tready && !$rose(m_axis_tvalid))
        else $error("write transfer stalled the input or gave a result");

    // A point keeps the input closed in S_ZONE and in the state that follows it
    a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && (s_axis_tuser == OP_POINT) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("point finished too early");

endmodule

bind point_box_polygon_zone_filter pbpzf_chk u_pbpzf_chk (.*);

`default_nettype wire

// ===== test/point_box_polygon_zone_filter_tb.sv =====
`timescale 1ns / 100ps

module point_box_polygon_zone_filter_tb;
    import pbpzf_pkg::*;

    localparam int ZONE_NUM    = 4;
    localparam int VERT_NUM    = 8;
    localparam int Q_ONE       = 65536;      // 1.0 m in Q16.16
    localparam int IDLE_PCT    = 38;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_WAIT  = 64;

    // op code the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [1:0]         zn;
        logic [3:0]         vtx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0]         inten;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } lidar_item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  inten;
    } kept_point_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // filter state as the block should hold it
    logic signed [31:0] box [0:5];
    logic signed [31:0] vtx_x [0:ZONE_NUM*VERT_NUM-1];
    logic signed [31:0] vtx_y [0:ZONE_NUM*VERT_NUM-1];
    int                 zone_cnt [0:ZONE_NUM-1];
    logic signed [31:0] zone_lo [0:ZONE_NUM-1];
    logic signed [31:0] zone_hi [0:ZONE_NUM-1];

    // vertices as written by the generator, used to aim points at edges
    logic signed [31:0] gen_vx [0:ZONE_NUM*VERT_NUM-1];
    logic signed [31:0] gen_vy [0:ZONE_NUM*VERT_NUM-1];

    lidar_item_t pending_items[$];
    kept_point_t kept_points[$];
    lidar_item_t cur_item;
    kept_point_t want;
    bit          sent = 1'b0;
    bit          no_stall = 1'b0;
    int          failures = 0;
    int          cycle_count = 0;

    point_box_polygon_zone_filter #(
        .ZONES    (ZONE_NUM),
        .VERTICES (VERT_NUM)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // zone, vertex, coord_x, coord_y, coord_z,
                                          // intensity, height_low, height_high
        .s_axis_tuser  (s_axis_tuser),    // op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // out_x, out_y, out_z, out_intensity
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [S_TDATA_W-1:0] pack_item(input lidar_item_t it);
        return {2'b00, it.hi, it.lo, it.inten, it.z, it.y, it.x, it.vtx, it.zn};
    endfunction

    // even-odd ray cast, exact cross-multiplied edge test at 128 bits
    function automatic bit inside_zone(input int zn, input longint px, input longint py);
        int                 n;
        int                 j;
        bit                 odd;
        longint             xi, yi, xj, yj;
        logic signed [127:0] dy, ry, lhs, rhs;
        n = zone_cnt[zn];
        odd = 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            xi = vtx_x[zn*VERT_NUM + i];
            yi = vtx_y[zn*VERT_NUM + i];
            xj = vtx_x[zn*VERT_NUM + j];
            yj = vtx_y[zn*VERT_NUM + j];
            if ((yi > py) != (yj > py))
            begin
                dy = yj - yi;
                ry = py - yi;
                if (dy < 0)
                begin
                    dy = -dy;
                    ry = -ry;
                end
                lhs = (px - xi) * dy;
                rhs = (xj - xi) * ry;
                if (lhs < rhs)
                    odd = !odd;
            end
            j = i;
        end
        return odd;
    endfunction

    function automatic bit point_kept(input longint px, input longint py, input longint pz);
        if (px >= box[CFG_X_MIN] && px <= box[CFG_X_MAX] &&
            py >= box[CFG_Y_MIN] && py <= box[CFG_Y_MAX] &&
            pz >= box[CFG_Z_MIN] && pz <= box[CFG_Z_MAX])
            return 1'b0;
        for (int k = 0; k < ZONE_NUM; k++)
        begin
            if (zone_cnt[k] != 0 && pz >= zone_lo[k] && pz <= zone_hi[k] &&
                inside_zone(k, px, py))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // apply one accepted item to the zone store, or predict its output
    function automatic void absorb_item(input lidar_item_t it);
        kept_point_t kp;
        case (it.op)
            OP_VERTEX:
            begin
                if (it.zn < ZONE_NUM && it.vtx < VERT_NUM)
                begin
                    vtx_x[it.zn*VERT_NUM + it.vtx] = it.x;
                    vtx_y[it.zn*VERT_NUM + it.vtx] = it.y;
                end
            end
            OP_ZONE:
            begin
                if (it.zn < ZONE_NUM)
                begin
                    zone_cnt[it.zn] = (it.vtx > VERT_NUM) ? VERT_NUM : it.vtx;
                    zone_lo[it.zn] = it.lo;
                    zone_hi[it.zn] = it.hi;
                end
            end
            OP_POINT:
            begin
                if (point_kept(it.x, it.y, it.z))
                begin
                    kp.x = it.x;
                    kp.y = it.y;
                    kp.z = it.z;
                    kp.inten = it.inten;
                    kept_points = {kept_points, kp};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_raw(input logic [OP_W-1:0] op, input logic [1:0] zn,
                                      input logic [3:0] vtx,
                                      input logic signed [31:0] x, y, z,
                                      input logic [7:0] inten,
                                      input logic signed [31:0] lo, hi);
        lidar_item_t it;
        it.op = op;
        it.zn = zn;
        it.vtx = vtx;
        it.x = x;
        it.y = y;
        it.z = z;
        it.inten = inten;
        it.lo = lo;
        it.hi = hi;
        pending_items = {pending_items, it};
    endfunction

    // unused fields get random filler
    function automatic void queue_point(input logic signed [31:0] x, y, z,
                                        input logic [7:0] inten);
        queue_raw(OP_POINT, 2'($urandom), 4'($urandom), x, y, z, inten, $urandom, $urandom);
    endfunction

    function automatic void queue_vertex(input logic [1:0] zn, input logic [3:0] idx,
                                         input logic signed [31:0] x, y);
        queue_raw(OP_VERTEX, zn, idx, x, y, $urandom, 8'($urandom), $urandom, $urandom);
        if (idx < VERT_NUM)
        begin
            gen_vx[zn*VERT_NUM + idx] = x;
            gen_vy[zn*VERT_NUM + idx] = y;
        end
    endfunction

    function automatic void queue_zone(input logic [1:0] zn, input logic [3:0] cnt,
                                       input logic signed [31:0] lo, hi);
        queue_raw(OP_ZONE, zn, cnt, $urandom, $urandom, $urandom, 8'($urandom), lo, hi);
    endfunction

    function automatic logic signed [31:0] spread(input int lim);
        return $signed($urandom_range(2*lim)) - lim;
    endfunction

    // a value on or next to a crop bound, or somewhere near the box
    function automatic logic signed [31:0] near_bound(input logic signed [31:0] lo, hi);
        int sel;
        sel = $urandom_range(2);
        if (sel == 0)
            return lo + $signed($urandom_range(2)) - 1;
        if (sel == 1)
            return hi + $signed($urandom_range(2)) - 1;
        return spread(3 * Q_ONE / 2);
    endfunction

    // random polygon, sometimes degenerate, oversized or with odd height range
    function automatic void queue_zone_layout(input int zn);
        int                 n;
        int                 sel;
        bit                 wide;
        logic [3:0]         cnt;
        logic signed [31:0] lo, hi, tmp;
        n = $urandom_range(3, VERT_NUM);
        wide = ($urandom_range(9) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (wide)
                queue_vertex(2'(zn), 4'(i), $urandom, $urandom);
            else
                queue_vertex(2'(zn), 4'(i), spread(20*Q_ONE), spread(20*Q_ONE));
        end
        if ($urandom_range(4) == 0)
            queue_vertex(2'(zn), 4'($urandom_range(VERT_NUM, 15)), $urandom, $urandom);
        sel = $urandom_range(19);
        cnt = 4'((sel == 0) ? $urandom_range(0, 2) :
                 (sel == 1) ? $urandom_range(9, 15) : n);
        lo = spread(5*Q_ONE);
        hi = lo + $signed($urandom_range(10*Q_ONE));
        if (sel == 2)
        begin
            tmp = lo;
            lo = hi + 1;
            hi = tmp;
        end
        else if (sel == 3)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        queue_zone(2'(zn), cnt, lo, hi);
    endfunction

    task automatic random_burst(input int count);
        int                 made;
        int                 r;
        int                 s;
        int                 k;
        logic signed [31:0] px, py, pz;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(99);
            if (r < 5)
            begin
                queue_zone_layout($urandom_range(ZONE_NUM-1));
                made++;
            end
            else if (r < 9)
            begin
                queue_vertex(2'($urandom), 4'($urandom), spread(20*Q_ONE), spread(20*Q_ONE));
                made++;
            end
            else if (r < 11)
                queue_raw(OP_UNUSED, 2'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                          8'($urandom), $urandom, $urandom);
            else
            begin
                s = $urandom_range(99);
                if (s < 45)
                begin
                    px = spread(25*Q_ONE);
                    py = spread(25*Q_ONE);
                    pz = spread(6*Q_ONE);
                end
                else if (s < 65)
                begin
                    px = near_bound(box[CFG_X_MIN], box[CFG_X_MAX]);
                    py = near_bound(box[CFG_Y_MIN], box[CFG_Y_MAX]);
                    pz = near_bound(box[CFG_Z_MIN], box[CFG_Z_MAX]);
                end
                else if (s < 80)
                begin
                    px = $urandom;
                    py = $urandom;
                    pz = $urandom;
                end
                else
                begin
                    // on or beside a vertex, so edges and corners get hit exactly
                    k = $urandom_range(ZONE_NUM*VERT_NUM-1);
                    px = gen_vx[k] + $signed($urandom_range(2)) - 1;
                    py = gen_vy[k] + $signed($urandom_range(2)) - 1;
                    pz = spread(6*Q_ONE);
                end
                queue_point(px, py, pz, 8'($urandom));
                made++;
            end
        end
    endtask

    task automatic write_crop(input logic [CFG_IDX_W-1:0] idx, input logic signed [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        box[idx] = val;
    endtask

    task automatic load_box(input logic signed [31:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi);
        write_crop(CFG_X_MIN, x_lo);
        write_crop(CFG_X_MAX, x_hi);
        write_crop(CFG_Y_MIN, y_lo);
        write_crop(CFG_Y_MAX, y_hi);
        write_crop(CFG_Z_MIN, z_lo);
        write_crop(CFG_Z_MAX, z_hi);
    endtask

    // hold the sender until all queued items are taken and every kept point is out
    task automatic settle();
        int guard;
        while (pending_items.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        guard = 0;
        while (kept_points.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // input driver: new transfer offered on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
            if (!s_axis_tvalid || sent)
            begin
                sent = 1'b0;
                if (pending_items.size() != 0 && (no_stall || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_item = pending_items.pop_front();
                    s_axis_tdata <= pack_item(cur_item);
                    s_axis_tuser <= cur_item.op;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // input transfer: update the zone store or predict the point
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            absorb_item(cur_item);
            sent = 1'b1;
        end
    end

    // output transfer: check against the oldest kept point
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (kept_points.size() == 0)
            begin
                $error("unexpected output transfer, tdata %h", m_axis_tdata);
                failures++;
            end
            else
            begin
                want = kept_points.pop_front();
                if (m_axis_tdata[31:0] !== want.x)
                begin
                    $error("out_x: expected %h, got %h", want.x, m_axis_tdata[31:0]);
                    failures++;
                end
                if (m_axis_tdata[63:32] !== want.y)
                begin
                    $error("out_y: expected %h, got %h", want.y, m_axis_tdata[63:32]);
                    failures++;
                end
                if (m_axis_tdata[95:64] !== want.z)
                begin
                    $error("out_z: expected %h, got %h", want.z, m_axis_tdata[95:64]);
                    failures++;
                end
                if (m_axis_tdata[103:96] !== want.inten)
                begin
                    $error("out_intensity: expected %h, got %h", want.inten,
                           m_axis_tdata[103:96]);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL point_box_polygon_zone_filter");
            $finish;
        end
    end

    initial
    begin
        box[CFG_X_MIN] = RST_X_MIN;
        box[CFG_X_MAX] = RST_X_MAX;
        box[CFG_Y_MIN] = RST_Y_MIN;
        box[CFG_Y_MAX] = RST_Y_MAX;
        box[CFG_Z_MIN] = RST_Z_MIN;
        box[CFG_Z_MAX] = RST_Z_MAX;
        foreach (vtx_x[i])
        begin
            vtx_x[i] = '0;
            vtx_y[i] = '0;
            gen_vx[i] = '0;
            gen_vy[i] = '0;
        end
        foreach (zone_cnt[i])
        begin
            zone_cnt[i] = 0;
            zone_lo[i] = '0;
            zone_hi[i] = '0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // crop box at reset defaults, bounds inclusive
        queue_point(0, 0, 0, 8'h5a);
        queue_point(-32768, -32768, -32768, 8'h01);
        queue_point(32768, 32768, 45875, 8'h02);
        queue_point(32768, 32768, 45876, 8'h03);
        queue_point(-32769, 0, 0, 8'h04);
        queue_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 8'h00);
        queue_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 8'hff);
        // unused op code, all ones
        queue_raw(OP_UNUSED, 2'b11, 4'hf, '1, '1, '1, 8'hff, '1, '1);
        // square zone 0, plus a vertex write past the table
        queue_vertex(2'd0, 4'd0, -10*Q_ONE, -10*Q_ONE);
        queue_vertex(2'd0, 4'd1, 10*Q_ONE, -10*Q_ONE);
        queue_vertex(2'd0, 4'd2, 10*Q_ONE, 10*Q_ONE);
        queue_vertex(2'd0, 4'd3, -10*Q_ONE, 10*Q_ONE);
        queue_vertex(2'd0, 4'd8, 100*Q_ONE, 100*Q_ONE);
        queue_zone(2'd0, 4'd4, -Q_ONE, 3*Q_ONE);
        queue_point(5*Q_ONE, 5*Q_ONE, 2*Q_ONE, 8'h10);
        queue_point(5*Q_ONE, 5*Q_ONE, 4*Q_ONE, 8'h11);
        queue_point(-10*Q_ONE, -10*Q_ONE, 0, 8'h12);
        queue_point(20*Q_ONE, 0, 0, 8'h13);
        // oversized count saturates; two-vertex zone never holds a point
        queue_zone(2'd1, 4'd15, 32'sh80000000, 32'sh7fffffff);
        queue_vertex(2'd2, 4'd1, 4*Q_ONE, 4*Q_ONE);
        queue_zone(2'd2, 4'd2, 32'sh80000000, 32'sh7fffffff);
        queue_point(2*Q_ONE, 2*Q_ONE, 0, 8'h14);
        // inverted height range on the square drops nothing
        queue_zone(2'd0, 4'd4, 3*Q_ONE, -Q_ONE);
        queue_point(5*Q_ONE, 5*Q_ONE, 2*Q_ONE, 8'h15);
        settle();

        // small random box
        load_box(-$signed($urandom_range(3*Q_ONE)), $urandom_range(3*Q_ONE),
                 -$signed($urandom_range(3*Q_ONE)), $urandom_range(3*Q_ONE),
                 -$signed($urandom_range(3*Q_ONE)), $urandom_range(3*Q_ONE));
        random_burst(300);
        settle();

        // long run with no stalls on either side
        no_stall = 1'b1;
        load_box(-$signed($urandom_range(2*Q_ONE)), $urandom_range(2*Q_ONE),
                 -$signed($urandom_range(2*Q_ONE)), $urandom_range(2*Q_ONE),
                 -$signed($urandom_range(2*Q_ONE)), $urandom_range(2*Q_ONE));
        random_burst(250);
        settle();
        no_stall = 1'b0;

        // box spans everything: every point dropped
        load_box(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                 32'sh80000000, 32'sh7fffffff);
        random_burst(60);
        settle();

        // inverted box drops nothing by itself
        load_box(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
        random_burst(300);
        settle();

        // fully random bounds
        load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_burst(300);
        settle();

        if (kept_points.size() != 0)
        begin
            $error("%0d kept points never came out", kept_points.size());
            failures++;
        end
        if (failures == 0)
            $display("PASS point_box_polygon_zone_filter");
        else
            $display("FAIL point_box_polygon_zone_filter");
        $finish;
    end

endmodule
